// File: hw/rtl/knc_pkg.sv
// ----------------------------------------------------------------------------
// knc_pkg
// Types and constants shared by the core distance selector modules.
// ----------------------------------------------------------------------------
package knc_pkg;

  localparam int DIST_W  = 32;
  localparam int POINT_W = 14;
  localparam int RANK_W  = 5;

  localparam logic [RANK_W-1:0] MIN_PTS_RESET = 5'd5;
  localparam logic [DIST_W-1:0] INF_DIST      = '1;

  // one entry of a distance matrix row
  typedef struct packed {
    logic [DIST_W-1:0]  dist_value;
    logic [POINT_W-1:0] point_row;
    logic [POINT_W-1:0] point_column;
    logic               row_end;
  } dist_in_t;

  // one core distance result
  typedef struct packed {
    logic [DIST_W-1:0]  core_distance;
    logic [POINT_W-1:0] core_row;
  } core_out_t;

  // command from the input stage to the sorted list
  typedef struct packed {
    logic update;
    logic merge;
    logic clear;
  } list_cmd_t;

endpackage

// File: hw/rtl/knc_sorted_list.sv
// ----------------------------------------------------------------------------
// knc_sorted_list
// Ascending list of the smallest distances of the current row, with a
// parallel compare-and-insert and rank selection.
// ----------------------------------------------------------------------------
module knc_sorted_list #(
  parameter int MAX_K = 16,
  parameter int IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  knc_pkg::list_cmd_t        cmd,
  input  logic [knc_pkg::DIST_W-1:0] new_dist,
  input  logic [IDX_W-1:0]          rank_idx,
  output logic [knc_pkg::DIST_W-1:0] sel_dist
);

  logic [knc_pkg::DIST_W-1:0] list_r   [MAX_K];
  logic [knc_pkg::DIST_W-1:0] list_nxt [MAX_K];
  logic [knc_pkg::DIST_W-1:0] merged   [MAX_K];
  logic [MAX_K-1:0]           above;

  // slots holding a larger value move down by one, the first of them takes new_dist
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      above[i] = cmd.merge && (list_r[i] > new_dist);
    end
    for (int i = 0; i < MAX_K; i++) begin
      if (!above[i]) begin
        merged[i] = list_r[i];
      end else if (i == 0) begin
        merged[i] = new_dist;
      end else if (!above[(i > 0) ? i - 1 : 0]) begin
        merged[i] = new_dist;
      end else begin
        merged[i] = list_r[(i > 0) ? i - 1 : 0];
      end
    end
  end

  assign sel_dist = merged[rank_idx];

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      if (!cmd.update) begin
        list_nxt[i] = list_r[i];
      end else if (cmd.clear) begin
        list_nxt[i] = knc_pkg::INF_DIST;
      end else begin
        list_nxt[i] = merged[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_K; i++) begin
        list_r[i] <= knc_pkg::INF_DIST;
      end
    end else begin
      for (int i = 0; i < MAX_K; i++) begin
        list_r[i] <= list_nxt[i];
      end
    end
  end

  // end of row leaves an empty list behind
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && cmd.clear) |=> (list_r[0] == knc_pkg::INF_DIST))
    else $error("list not cleared after end of row");

  // list stays in ascending order, checked at its first and last entries
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    list_r[0] <= list_r[MAX_K-1])
    else $error("sorted list out of order");

  // no change at the first or last entry without an update
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.update |=> $stable(list_r[0]) && $stable(list_r[MAX_K-1]))
    else $error("list changed without an item");

endmodule

// File: hw/rtl/knc_out_buf.sv
// ----------------------------------------------------------------------------
// knc_out_buf
// Two-entry result buffer so the input side keeps moving while a result
// waits on the output.
// ----------------------------------------------------------------------------
module knc_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  knc_pkg::core_out_t push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output knc_pkg::core_out_t out_item
);

  knc_pkg::core_out_t mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign out_valid  = (count_r != 2'd0);
  assign out_item   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == 2'd0) || (count_r == 2'd2)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("result buffer pointers disagree with count");

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("waiting result changed");

endmodule

// File: hw/rtl/kth_nearest_core_distance_core.sv
// ----------------------------------------------------------------------------
// kth_nearest_core_distance_core
// Core distance selector: min_pts-th smallest non-self distance per row.
// ----------------------------------------------------------------------------
// Streams one row of a distance matrix and returns, at the item flagged
// row_end, the min_pts-th smallest distance whose column differs from the row
// (all-ones when the row has too few). Takes one item per clock cycle; a
// result passes the input stage register and the result buffer before it
// leaves the output. The rate is set by the sorted list of MAX_K entries,
// which compares the new distance against every entry in parallel and
// inserts it. Results queue in a two-entry buffer, so the input only
// stalls when an end of row meets a full buffer. min_pts is clamped to
// 1..MAX_K and may only be written while no item is in flight.
// ----------------------------------------------------------------------------
module kth_nearest_core_distance_core #(
  parameter int MAX_K = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  knc_pkg::dist_in_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output knc_pkg::core_out_t          out_item,
  input  logic                        cfg_wr_en,
  input  logic [knc_pkg::RANK_W-1:0]  cfg_wr_data
);

  localparam int IDX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int RANK_X = 7;

  logic [knc_pkg::RANK_W-1:0] min_pts_r;
  logic                       s1_valid_r, s1_valid_nxt;
  knc_pkg::dist_in_t          s1_item_r;
  logic                       s1_fire;
  logic                       buf_ready;
  logic                       in_take;
  logic [RANK_X-1:0]          rank_w;
  logic [IDX_W-1:0]           rank_idx;
  knc_pkg::list_cmd_t         list_cmd;
  logic [knc_pkg::DIST_W-1:0] sel_dist;
  knc_pkg::core_out_t         result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pts_r <= knc_pkg::MIN_PTS_RESET;
    end else if (cfg_wr_en) begin
      min_pts_r <= cfg_wr_data;
    end
  end

  // rank clamp: zero reads as one, beyond the list depth saturates
  always_comb begin
    rank_w = {{(RANK_X-knc_pkg::RANK_W){1'b0}}, min_pts_r};
    if (rank_w == '0) begin
      rank_w = RANK_X'(1);
    end else if (rank_w > RANK_X'(MAX_K)) begin
      rank_w = RANK_X'(MAX_K);
    end
    rank_idx = IDX_W'(rank_w - RANK_X'(1));
  end

  // an item without a result never waits on the output
  assign s1_fire  = s1_valid_r && (!s1_item_r.row_end || buf_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  assign list_cmd.update = s1_fire;
  assign list_cmd.merge  = (s1_item_r.point_column != s1_item_r.point_row);
  assign list_cmd.clear  = s1_item_r.row_end;

  knc_sorted_list #(
    .MAX_K (MAX_K),
    .IDX_W (IDX_W)
  ) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (list_cmd),
    .new_dist (s1_item_r.dist_value),
    .rank_idx (rank_idx),
    .sel_dist (sel_dist)
  );

  assign result.core_distance = sel_dist;
  assign result.core_row      = s1_item_r.point_row;

  knc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_fire && s1_item_r.row_end),
    .push_data  (result),
    .push_ready (buf_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  // a held item keeps its payload until it moves on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost a stalled item");

  // an empty input stage always takes the next item
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  // a non-ending item always advances
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_item_r.row_end) |-> s1_fire)
    else $error("item without result stalled");

endmodule

// File: verif/tb_kth_nearest_core_distance_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kth_nearest_core_distance_core
// Self-checking bench for the core distance selector.
// ----------------------------------------------------------------------------
// Rows of a distance matrix are streamed through the input channel. A local
// sorted list tracks the smallest non-self distances of the current row and
// predicts the core distance emitted at each row end. Results are checked in
// order against the predictions. A directed part covers short rows,
// self-distances, ties, all-ones distances and row index changes inside a
// row. Random rows then follow under several min_pts settings, including
// zero and values above the list depth, with random idle bursts on both
// channels except in the final phase.
// ----------------------------------------------------------------------------
module tb_kth_nearest_core_distance_core;

  localparam int LIST_DEPTH  = 16;
  localparam int IDLE_LIMIT  = 1000;
  localparam int SETTLE_CYC  = 10;
  localparam int PHASE_ITEMS = 78;
  localparam int NUM_PHASES  = 7;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  knc_pkg::dist_in_t            in_item = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  knc_pkg::core_out_t           out_item;
  logic                         cfg_wr_en = 1'b0;
  logic [knc_pkg::RANK_W-1:0]   cfg_wr_data = '0;

  // predictor state
  logic [knc_pkg::DIST_W-1:0]   nearest_dists [LIST_DEPTH];
  logic [knc_pkg::RANK_W-1:0]   min_pts_reg;

  knc_pkg::dist_in_t            dist_pending [$];
  knc_pkg::core_out_t           core_expected [$];
  knc_pkg::core_out_t           want_core;

  int                  fail_count = 0;
  int                  idle_cycles = 0;
  int unsigned         send_gap = 0;
  int unsigned         recv_stall = 0;
  bit                  idling_on = 1'b1;

  kth_nearest_core_distance_core #(
    .MAX_K (LIST_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_nearest();
    int i;
    for (i = 0; i < LIST_DEPTH; i++) begin
      nearest_dists[i] = knc_pkg::INF_DIST;
    end
  endfunction

  // sorted insert, equal values land after existing ones
  function automatic void merge_distance(input logic [knc_pkg::DIST_W-1:0] v);
    int pos;
    int i;
    pos = 0;
    while (pos < LIST_DEPTH && nearest_dists[pos] <= v) pos++;
    if (pos < LIST_DEPTH) begin
      for (i = LIST_DEPTH - 1; i > pos; i--) begin
        nearest_dists[i] = nearest_dists[i-1];
      end
      nearest_dists[pos] = v;
    end
  endfunction

  function automatic void predict_core(input knc_pkg::dist_in_t it);
    int rank;
    knc_pkg::core_out_t res;
    if (it.point_column != it.point_row) merge_distance(it.dist_value);
    if (it.row_end) begin
      rank = min_pts_reg;
      if (rank < 1) rank = 1;
      if (rank > LIST_DEPTH) rank = LIST_DEPTH;
      res.core_distance = nearest_dists[rank-1];
      res.core_row      = it.point_row;
      core_expected.push_back(res);
      clear_nearest();
    end
  endfunction

  function automatic logic [knc_pkg::DIST_W-1:0] pick_distance(input int unsigned mode);
    logic [knc_pkg::DIST_W-1:0] d;
    case (mode)
      0: d = $urandom();
      1: d = $urandom_range(0, 20);          // narrow range, lots of ties
      2: begin
        case ($urandom_range(0, 9))
          0:       d = '0;
          1:       d = knc_pkg::INF_DIST;
          2:       d = knc_pkg::INF_DIST - 1;
          default: d = $urandom();
        endcase
      end
      default: d = {1'b0, 31'($urandom())};  // non-negative float patterns
    endcase
    return d;
  endfunction

  function automatic void push_item(input logic [knc_pkg::DIST_W-1:0] d,
                                    input int unsigned row,
                                    input int unsigned col, input bit last);
    knc_pkg::dist_in_t it;
    it.dist_value   = d;
    it.point_row    = knc_pkg::POINT_W'(row);
    it.point_column = knc_pkg::POINT_W'(col);
    it.row_end      = last;
    dist_pending.push_back(it);
  endfunction

  function automatic void queue_row(input int unsigned len, input int unsigned row,
                                    input int unsigned mode);
    int unsigned i;
    int unsigned r;
    int unsigned c;
    for (i = 0; i < len; i++) begin
      r = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 16383) : row;
      c = ($urandom_range(0, 5) == 0) ? r : $urandom_range(0, 16383);
      push_item(pick_distance(mode), r, c, i == len - 1);
    end
  endfunction

  function automatic void queue_random_rows(input int unsigned budget);
    int unsigned count;
    int unsigned len;
    int unsigned row;
    count = 0;
    while (count < budget) begin
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(1, 4);
        3:       len = $urandom_range(17, 30);
        default: len = $urandom_range(5, 20);
      endcase
      case ($urandom_range(0, 7))
        0:       row = 0;
        1:       row = 16383;
        default: row = $urandom_range(0, 16383);
      endcase
      queue_row(len, row, $urandom_range(0, 3));
      count += len;
    end
  endfunction

  task automatic queue_directed();
    // lone self entry ending the row
    push_item(32'd0, 0, 0, 1'b1);
    // four real neighbors plus a self entry: too few for rank five
    push_item(32'd7, 16383, 0, 1'b0);
    push_item(32'd3, 16383, 16383, 1'b0);
    push_item(knc_pkg::INF_DIST, 16383, 1, 1'b0);
    push_item(32'd0, 16383, 100, 1'b0);
    push_item(32'd5, 16383, 16382, 1'b1);
    // ties, self entry on the ending item
    push_item(32'd9, 1, 0, 1'b0);
    push_item(32'd9, 1, 2, 1'b0);
    push_item(32'd9, 1, 3, 1'b0);
    push_item(32'd2, 1, 4, 1'b0);
    push_item(32'd9, 1, 5, 1'b0);
    push_item(32'd1, 1, 1, 1'b1);
    // row index wanders inside the row, all-ones distance fills the rank
    push_item(32'd4, 2, 0, 1'b0);
    push_item(32'd6, 3, 1, 1'b0);
    push_item(32'd8, 5, 7, 1'b0);
    push_item(32'd1, 2, 9, 1'b0);
    push_item(knc_pkg::INF_DIST, 200, 3, 1'b1);
    // exactly rank-many entries, some with large values
    push_item(knc_pkg::INF_DIST - 1, 8191, 0, 1'b0);
    push_item(32'd0, 8191, 1, 1'b0);
    push_item(32'h7F80_0000, 8191, 2, 1'b0);
    push_item(32'd1, 8191, 3, 1'b0);
    push_item(32'h8000_0000, 8191, 16383, 1'b1);
  endtask

  task automatic drain_and_settle();
    do @(negedge clk);
    while (dist_pending.size() != 0 || in_valid || core_expected.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_min_pts(input logic [knc_pkg::RANK_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    min_pts_reg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) predict_core(in_item);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (dist_pending.size() != 0) begin
          if (idling_on && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 5);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_item  <= dist_pending.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (core_expected.size() == 0) begin
          $error("unexpected item: core_distance %h core_row %0d",
                 out_item.core_distance, out_item.core_row);
          fail_count++;
        end else begin
          want_core = core_expected.pop_front();
          if (out_item.core_distance !== want_core.core_distance) begin
            $error("core_distance: expected %h, got %h",
                   want_core.core_distance, out_item.core_distance);
            fail_count++;
          end
          if (out_item.core_row !== want_core.core_row) begin
            $error("core_row: expected %0d, got %0d",
                   want_core.core_row, out_item.core_row);
            fail_count++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 5);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** kth_nearest_core_distance_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [knc_pkg::RANK_W-1:0] rank_plan [NUM_PHASES];
    int ph;
    clear_nearest();
    min_pts_reg = knc_pkg::MIN_PTS_RESET;
    rank_plan[0] = 5'd1;
    rank_plan[1] = 5'd16;
    rank_plan[2] = 5'd0;
    rank_plan[3] = 5'd31;
    rank_plan[4] = 5'd17;
    rank_plan[5] = knc_pkg::RANK_W'($urandom_range(2, 15));
    rank_plan[6] = 5'd8;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_directed();
    drain_and_settle();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_min_pts(rank_plan[ph]);
      if (ph == NUM_PHASES - 1) idling_on = 1'b0;
      queue_random_rows(PHASE_ITEMS);
      drain_and_settle();
    end

    if (core_expected.size() != 0) begin
      $error("%0d expected items never arrived", core_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** kth_nearest_core_distance_core: PASSED **");
    end else begin
      $display("** kth_nearest_core_distance_core: FAILED **");
    end
    $finish;
  end

endmodule
